>>> rtl/core/mec_pkg.sv
`timescale 1ns / 1ps
package mec_pkg;

  typedef enum logic [1:0] {
    IterIdle,
    IterMul,
    IterUpd,
    IterDone
  } iter_state_e;

  typedef enum logic [1:0] {
    ColIdle,
    ColDiv,
    ColMul,
    ColOut
  } col_state_e;

  typedef struct packed {
    logic [15:0] count;
    logic        in_set;
  } iter_res_t;

  function automatic logic [7:0] pal_k(input logic [1:0] seg, input logic [1:0] ch);
    logic [7:0] k;
    begin
      k = 8'd0;
      case (seg)
        2'd0: k = (ch == 2'd0) ? 8'd0 : (ch == 2'd1) ? 8'd149 : 8'd255;
        2'd1: k = (ch == 2'd0) ? 8'd255 : (ch == 2'd1) ? 8'd106 : 8'd0;
        2'd2: k = (ch == 2'd0) ? 8'd0 : (ch == 2'd1) ? 8'd61 : 8'd255;
        default: k = (ch == 2'd0) ? 8'd255 : (ch == 2'd1) ? 8'd195 : 8'd0;
      endcase
      return k;
    end
  endfunction

endpackage

>>> rtl/core/mec_front.sv
`timescale 1ns / 1ps
// Skid queue of two entries between the input stream and the iterator.
module mec_front #(
  parameter int unsigned DW = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [DW-1:0] in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [DW-1:0] out_data_o
);
  logic [DW-1:0] mem_q [2];
  logic [DW-1:0] mem_d0, mem_d1;
  logic          rd_q, rd_d, wr_q, wr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
    rd_d  = rd_q ^ pop;
    wr_d  = wr_q ^ push;
    mem_d0 = mem_q[0];
    mem_d1 = mem_q[1];
    if (push && !wr_q) mem_d0 = in_data_i;
    if (push && wr_q) mem_d1 = in_data_i;
  end

  always_ff @(posedge clk_i) begin
    mem_q[0] <= mem_d0;
    mem_q[1] <= mem_d1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
      wr_q  <= wr_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> (rd_q == wr_q)) else $error("empty queue pointers differ");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> (rd_q == wr_q)) else $error("full queue pointers differ");
endmodule

>>> rtl/core/mec_iter.sv
`timescale 1ns / 1ps
// Each escape-time step tests escape and limit, then forms sums, saturation and new products.
module mec_iter #(
  parameter int unsigned CW = 32,
  parameter int unsigned FB = 28
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [15:0]                  limit_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [CW-1:0]         c_re_i,
  input  logic signed [CW-1:0]         c_im_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output mec_pkg::iter_res_t           out_res_o
);
  localparam int unsigned PW = 2 * CW + 2;
  localparam logic signed [PW-1:0] Four = PW'(1) <<< (2 * FB + 2);
  localparam logic signed [PW-1:0] CMax = (PW'(1) <<< (CW - 1)) - PW'(1);
  localparam logic signed [PW-1:0] CMin = -(PW'(1) <<< (CW - 1));

  mec_pkg::iter_state_e st_q, st_d;
  logic signed [CW-1:0] cr_q, ci_q, zr_q, zi_q, zr_d, zi_d;
  logic signed [PW-1:0] rr_q, ii_q, ri_q;
  logic [15:0] cnt_q, cnt_d;
  logic        inside_q, inside_d;
  logic signed [PW-1:0] re_w, im_w, re_s, im_s;

  function automatic logic signed [CW-1:0] sat(input logic signed [PW-1:0] v);
    logic signed [CW-1:0] r;
    begin
      if (v > CMax) r = CMax[CW-1:0];
      else if (v < CMin) r = CMin[CW-1:0];
      else r = v[CW-1:0];
      return r;
    end
  endfunction

  assign re_w = rr_q - ii_q + (PW'(cr_q) <<< FB);
  assign im_w = (ri_q <<< 1) + (PW'(ci_q) <<< FB);
  assign re_s = re_w >>> FB;
  assign im_s = im_w >>> FB;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      mec_pkg::IterIdle: if (in_valid_i) st_d = mec_pkg::IterMul;
      mec_pkg::IterMul: begin
        if (cnt_q >= limit_i || (rr_q + ii_q) > Four) st_d = mec_pkg::IterDone;
        else st_d = mec_pkg::IterUpd;
      end
      mec_pkg::IterUpd: st_d = mec_pkg::IterMul;
      mec_pkg::IterDone: if (out_ready_i) st_d = mec_pkg::IterIdle;
      default: st_d = mec_pkg::IterIdle;
    endcase
  end

  always_comb begin
    zr_d = zr_q;
    zi_d = zi_q;
    cnt_d = cnt_q;
    inside_d = inside_q;
    unique case (st_q)
      mec_pkg::IterIdle: begin
        zr_d = '0;
        zi_d = '0;
        cnt_d = '0;
      end
      mec_pkg::IterMul: inside_d = (cnt_q >= limit_i);
      mec_pkg::IterUpd: begin
        zr_d = sat(re_s);
        zi_d = sat(im_s);
        cnt_d = cnt_q + 16'd1;
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (st_q == mec_pkg::IterIdle);
  assign out_valid_o = (st_q == mec_pkg::IterDone);
  assign out_res_o.count  = cnt_q;
  assign out_res_o.in_set = inside_q;

  always_ff @(posedge clk_i) begin
    if (st_q == mec_pkg::IterIdle) begin
      cr_q <= c_re_i;
      ci_q <= c_im_i;
      rr_q <= '0;
      ii_q <= '0;
      ri_q <= '0;
    end else if (st_q == mec_pkg::IterUpd) begin
      rr_q <= PW'(sat(re_s)) * PW'(sat(re_s));
      ii_q <= PW'(sat(im_s)) * PW'(sat(im_s));
      ri_q <= PW'(sat(re_s)) * PW'(sat(im_s));
    end
    zr_q <= zr_d;
    zi_q <= zi_d;
    inside_q <= inside_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= mec_pkg::IterIdle;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == mec_pkg::IterUpd) |=> (st_q == mec_pkg::IterMul)) else $error("bad step order");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == mec_pkg::IterUpd) |-> (cnt_q < limit_i)) else $error("count passed limit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == mec_pkg::IterDone && !out_ready_i) |=> $stable(cnt_q))
    else $error("result count changed");
endmodule

>>> rtl/core/mec_colour.sv
`timescale 1ns / 1ps
// Restoring divider for count/limit, then palette products one channel a cycle.
module mec_colour (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        limit_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mec_pkg::iter_res_t in_res_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [39:0]        out_data_o
);
  mec_pkg::col_state_e st_q, st_d;
  logic [15:0] cnt_q, rem_q, rem_d, f_q, f_d;
  logic        inside_q;
  logic [4:0]  step_q, step_d;
  logic [1:0]  ch_q, ch_d;
  logic [7:0]  rgb_q [3];
  logic [16:0] trial;
  logic [7:0]  k, chv;
  logic [1:0]  seg;
  logic [26:0] prod;
  logic [22:0] t;

  assign trial = {rem_q, cnt_q[4'(15 - step_q[3:0])]} ;
  assign seg = f_q[15:14];
  assign k = mec_pkg::pal_k(seg, ch_q);

  always_comb begin
    prod = '0;
    chv = '0;
    t = '0;
    case (seg)
      2'd0: begin
        prod = 27'(k) * (27'(49152) + 27'(5) * 27'(f_q));
        chv = prod[24:17];
      end
      2'd1: begin
        t = 23'(k) * (23'(32768) - 23'(f_q));
        prod = 27'(4177920) - 27'(t);
        chv = prod[21:14];
      end
      2'd2: begin
        t = 23'(k) * (23'(f_q) - 23'(32768));
        prod = 27'(4177920) - 27'(t);
        chv = prod[21:14];
      end
      default: begin
        prod = 27'(k) * (27'(16384) + 27'(3) * (27'(65536) - 27'(f_q)));
        chv = prod[23:16];
      end
    endcase
    if (inside_q) chv = 8'd0;
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      mec_pkg::ColIdle: if (in_valid_i) st_d = mec_pkg::ColDiv;
      mec_pkg::ColDiv: if (step_q == 5'd31) st_d = mec_pkg::ColMul;
      mec_pkg::ColMul: if (ch_q == 2'd2) st_d = mec_pkg::ColOut;
      mec_pkg::ColOut: if (out_ready_i) st_d = mec_pkg::ColIdle;
      default: st_d = mec_pkg::ColIdle;
    endcase
  end

  always_comb begin
    rem_d = rem_q;
    f_d = f_q;
    step_d = step_q;
    ch_d = ch_q;
    unique case (st_q)
      mec_pkg::ColIdle: begin
        rem_d = '0;
        f_d = '0;
        step_d = '0;
        ch_d = '0;
      end
      mec_pkg::ColDiv: begin
        // Bits of count << 16: count bits first, then sixteen zeros.
        if (step_q < 5'd16) begin
          if (trial >= {1'b0, limit_i}) begin
            rem_d = 16'(trial - {1'b0, limit_i});
          end else begin
            rem_d = trial[15:0];
          end
        end else begin
          if ({rem_q, 1'b0} >= {1'b0, limit_i}) begin
            rem_d = 16'({rem_q, 1'b0} - {1'b0, limit_i});
            f_d = {f_q[14:0], 1'b1};
          end else begin
            rem_d = {rem_q[14:0], 1'b0};
            f_d = {f_q[14:0], 1'b0};
          end
        end
        step_d = step_q + 5'd1;
      end
      mec_pkg::ColMul: ch_d = ch_q + 2'd1;
      default: ;
    endcase
  end

  assign in_ready_o  = (st_q == mec_pkg::ColIdle);
  assign out_valid_o = (st_q == mec_pkg::ColOut);
  assign out_data_o  = {rgb_q[2], rgb_q[1], rgb_q[0], cnt_q};

  always_ff @(posedge clk_i) begin
    if (st_q == mec_pkg::ColIdle) begin
      cnt_q    <= in_res_i.count;
      inside_q <= in_res_i.in_set;
    end
    if (st_q == mec_pkg::ColMul) rgb_q[ch_q] <= chv;
    rem_q <= rem_d;
    f_q <= f_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= mec_pkg::ColIdle;
      step_q <= '0;
      ch_q   <= '0;
    end else begin
      st_q   <= st_d;
      step_q <= step_d;
      ch_q   <= ch_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == mec_pkg::ColMul) |-> (ch_q != 2'd3)) else $error("channel index out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(st_q == mec_pkg::ColMul) |-> (step_q == 5'd0)) else $error("divider not finished");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == mec_pkg::ColOut && !out_ready_i) |=> $stable(out_data_o))
    else $error("result changed while stalled");
endmodule

>>> rtl/core/mandelbrot_escape_colour.sv
`timescale 1ns / 1ps
// The iterator runs the escape-time steps, then the colour stage divides and applies the palette.
// The iterator takes a new point only when idle, and colouring of one point overlaps
// the iterations of the next point.
// Reset: asynchronous, active low; queues empty, max_iterations returns to 256.
module mandelbrot_escape_colour #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 28
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [15:0]                cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // c_real, c_imag
  input  logic [2*COORD_WIDTH-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // iterations, red, green, blue
  output logic [39:0]                m_axis_tdata
);
  logic [15:0] limit_q;
  logic [2*COORD_WIDTH-1:0] q_data;
  logic q_valid, q_ready, r_valid, r_ready;
  mec_pkg::iter_res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= 16'd256;
    else if (cfg_we_i) limit_q <= cfg_wdata_i;
  end

  mec_front #(.DW(2 * COORD_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_data_i(s_axis_tdata),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_data_o(q_data)
  );

  mec_iter #(.CW(COORD_WIDTH), .FB(FRAC_BITS)) u_iter (
    .clk_i, .rst_ni, .limit_i(limit_q),
    .in_valid_i(q_valid), .in_ready_o(q_ready),
    .c_re_i(q_data[COORD_WIDTH-1:0]), .c_im_i(q_data[2*COORD_WIDTH-1:COORD_WIDTH]),
    .out_valid_o(r_valid), .out_ready_i(r_ready), .out_res_o(res)
  );

  mec_colour u_colour (
    .clk_i, .rst_ni, .limit_i(limit_q),
    .in_valid_i(r_valid), .in_ready_o(r_ready), .in_res_i(res),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(m_axis_tdata)
  );
endmodule
